>>> hw/rtl/rrts_pkg.sv
package rrts_pkg;

    typedef logic [1:0] t_slot_state;
    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_slot_state ST_FREE     = 2'd0;
    localparam t_slot_state ST_RUNNING  = 2'd1;
    localparam t_slot_state ST_RUNNABLE = 2'd2;
    localparam t_slot_state ST_SLEEPING = 2'd3;

    localparam t_req REQ_CREATE = 2'd0;
    localparam t_req REQ_YIELD  = 2'd1;
    localparam t_req REQ_SLEEP  = 2'd2;
    localparam t_req REQ_EXIT   = 2'd3;

    localparam t_status STS_OK       = 2'd0;
    localparam t_status STS_FULL     = 2'd1;
    localparam t_status STS_HALTED   = 2'd2;
    localparam t_status STS_REJECTED = 2'd3;

    localparam int SLOT_OUT_W  = 2;
    localparam int TICK_OUT_W  = 32;
    localparam int SLEEP_IN_W  = 16;

endpackage

>>> hw/rtl/rrts_wake_unit.sv
module rrts_wake_unit import rrts_pkg::*; #(
    parameter int TICK_WIDTH = 32
) (
    input  logic [TICK_WIDTH-1:0] i_tick,
    input  logic [TICK_WIDTH-1:0] i_wake,
    input  t_slot_state           i_state,
    output logic                  o_due
);

    logic [TICK_WIDTH-1:0] diff;

    // due when the slot is sleeping and tick - wake, read as signed, is not negative
    assign diff  = i_tick - i_wake;
    assign o_due = (i_state == ST_SLEEPING) && !diff[TICK_WIDTH-1];

endmodule

>>> hw/rtl/rrts_pick.sv
module rrts_pick import rrts_pkg::*; #(
    parameter int THREADS = 4,
    parameter int IDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1
) (
    input  logic [THREADS-1:0] i_runnable,
    input  logic [IDX_W-1:0]   i_cur,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_next
);

    logic [IDX_W:0] sum;

    // round-robin from cur+1, ending at cur; smallest offset wins
    always_comb begin
        o_found = 1'b0;
        o_next  = '0;
        sum     = '0;
        for (int k = THREADS; k >= 1; k--) begin
            sum = {1'b0, i_cur} + (IDX_W + 1)'(k);
            if (sum >= (IDX_W + 1)'(THREADS)) begin
                sum = sum - (IDX_W + 1)'(THREADS);
            end
            if (i_runnable[sum[IDX_W-1:0]]) begin
                o_found = 1'b1;
                o_next  = sum[IDX_W-1:0];
            end
        end
    end

endmodule

>>> hw/rtl/round_robin_thread_scheduler_sleep_core.sv
// Channel  | Direction | Handshake              | Ports
// request  | in        | start high, busy low   | i_req_type, i_sleep_ticks
// result   | out       | o_done strobe, 1 cycle | o_running_slot, o_switched,
//          |           |                        | o_created_slot, o_status, o_tick_now
//
// Create, and any request while halted, gives its result in the cycle after the transfer.
// Yield, sleep and exit first update the current slot and the tick, then run the wake
// pass over all THREADS slots (one slot a cycle through the shared wake compare), then
// the round-robin pick. busy stays high meanwhile.
// Synchronous active-low reset; no clearing pass. The receiver cannot stall results.
module round_robin_thread_scheduler_sleep_core import rrts_pkg::*; #(
    parameter int THREADS     = 4,
    parameter int TICK_WIDTH  = 32,
    parameter int SLEEP_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [SLEEP_IN_W-1:0] i_sleep_ticks,
    output logic                  o_done,
    output logic [SLOT_OUT_W-1:0] o_running_slot,
    output logic                  o_switched,
    output logic [SLOT_OUT_W-1:0] o_created_slot,
    output logic [1:0]            o_status,
    output logic [TICK_OUT_W-1:0] o_tick_now
);

    localparam int IDX_W = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam logic [63:0] SLEEP_MASK = (64'd1 << SLEEP_WIDTH) - 64'd1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAKE = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_cur;
    logic [IDX_W-1:0]      r_before;
    logic [TICK_WIDTH-1:0] r_tick;
    logic                  r_halted;
    t_slot_state           r_slot [THREADS];
    logic [TICK_WIDTH-1:0] r_wake [THREADS];

    logic                  accept;
    t_req                  req;
    logic [SLEEP_IN_W-1:0] sleep_masked;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic                  due;
    logic [THREADS-1:0]    runnable;
    logic                  pick_found;
    logic [IDX_W-1:0]      pick_next;

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign req          = t_req'(i_req_type);
    assign sleep_masked = i_sleep_ticks & SLEEP_MASK[SLEEP_IN_W-1:0];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = THREADS - 1; i >= 0; i--) begin
            if (r_slot[i] == ST_FREE) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < THREADS; i++) begin
            runnable[i] = (r_slot[i] == ST_RUNNABLE);
        end
    end

    rrts_wake_unit #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_wake (
        .i_tick  (r_tick),
        .i_wake  (r_wake[r_idx]),
        .i_state (r_slot[r_idx]),
        .o_due   (due)
    );

    rrts_pick #(
        .THREADS (THREADS),
        .IDX_W   (IDX_W)
    ) u_pick (
        .i_runnable (runnable),
        .i_cur      (r_cur),
        .o_found    (pick_found),
        .o_next     (pick_next)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept && !r_halted && req != REQ_CREATE) begin
                    n_state = S_WAKE;
                end
            end
            S_WAKE: begin
                if (r_idx == IDX_W'(THREADS - 1)) begin
                    n_state = S_PICK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PICK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done   <= 1'b0;
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_cur    <= '0;
            r_before <= '0;
            r_tick   <= '0;
            r_halted <= 1'b0;
            for (int i = 0; i < THREADS; i++) begin
                r_slot[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
                r_wake[i] <= '0;
            end
        end else begin
            // create and refused requests answer at once, scheduling ones after the pick
            o_done  <= (r_state == S_PICK) ||
                       (accept && (r_halted || req == REQ_CREATE));
            r_state <= n_state;
            r_idx   <= n_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_before <= r_cur;
                        if (r_halted) begin
                            o_running_slot <= SLOT_OUT_W'(r_cur);
                            o_switched     <= 1'b0;
                            o_created_slot <= '0;
                            o_status       <= STS_REJECTED;
                            o_tick_now     <= TICK_OUT_W'(r_tick);
                        end else if (req == REQ_CREATE) begin
                            if (free_found) begin
                                r_slot[free_idx] <= ST_RUNNABLE;
                            end
                            o_running_slot <= SLOT_OUT_W'(r_cur);
                            o_switched     <= 1'b0;
                            o_created_slot <= free_found ? SLOT_OUT_W'(free_idx) : '0;
                            o_status       <= free_found ? STS_OK : STS_FULL;
                            o_tick_now     <= TICK_OUT_W'(r_tick);
                        end else begin
                            r_tick <= r_tick + 1'b1;
                            unique case (req)
                                REQ_YIELD: r_slot[r_cur] <= ST_RUNNABLE;
                                REQ_SLEEP: begin
                                    r_slot[r_cur] <= ST_SLEEPING;
                                    // wake time from the tick before this advance
                                    r_wake[r_cur] <= r_tick + TICK_WIDTH'(sleep_masked);
                                end
                                default:   r_slot[r_cur] <= ST_FREE;
                            endcase
                        end
                    end
                end
                S_WAKE: begin
                    if (due) begin
                        r_slot[r_idx] <= ST_RUNNABLE;
                    end
                end
                S_PICK: begin
                    o_created_slot <= '0;
                    o_tick_now     <= TICK_OUT_W'(r_tick);
                    if (pick_found) begin
                        r_slot[pick_next] <= ST_RUNNING;
                        r_cur             <= pick_next;
                        o_running_slot    <= SLOT_OUT_W'(pick_next);
                        o_switched        <= (pick_next != r_before);
                        o_status          <= STS_OK;
                    end else begin
                        r_halted       <= 1'b1;
                        o_running_slot <= SLOT_OUT_W'(r_cur);
                        o_switched     <= 1'b0;
                        o_status       <= STS_HALTED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
